// ===== rtl/msig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msig_pkg
// Shared types and constants of the masked byte signature scanner.
// ----------------------------------------------------------------------------
package msig_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 6;
	localparam int OFS_OUT_W  = 32;
	localparam int SLOT_MAX   = 32;
	localparam int OUTQ_DEPTH = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_0 = 3'd0,
		CFG_PATTERN_1 = 3'd1,
		CFG_PATTERN_2 = 3'd2,
		CFG_PATTERN_3 = 3'd3,
		CFG_WILDCARD  = 3'd4,
		CFG_LENGTH    = 3'd5,
		CFG_FIND_ALL  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             find_all;
	} ctl_t;

	typedef struct packed {
		logic [OFS_OUT_W-1:0] match_offset;
		logic                 is_match;
		logic                 last_of_region;
	} res_t;

endpackage

// ===== rtl/msig_ifc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msig_ifc
// Byte, result and configuration channels of the signature scanner.
// ----------------------------------------------------------------------------
interface msig_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       region_start;
	logic       region_last;

	modport source (output valid, data_byte, region_start, region_last, input ready);
	modport sink (input valid, data_byte, region_start, region_last, output ready);
endinterface

interface msig_out_if;
	logic                           valid;
	logic                           ready;
	logic [msig_pkg::OFS_OUT_W-1:0] match_offset;
	logic                           is_match;
	logic                           last_of_region;

	modport source (output valid, match_offset, is_match, last_of_region, input ready);
	modport sink (input valid, match_offset, is_match, last_of_region, output ready);
endinterface

interface msig_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [msig_pkg::CFG_IDX_W-1:0]  index;
	logic [msig_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/msig_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msig_cell
// One window cell: holds one byte, passes it on, compares it to its
// aligned pattern byte.
// ----------------------------------------------------------------------------
module msig_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] byte_in,
	input  logic       care,
	input  logic [7:0] pat,
	output logic [7:0] byte_q,
	output logic       hit
);

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign hit = !care || (byte_q == pat);

endmodule

// ===== rtl/msig_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msig_cfg
// Configuration registers and per-cell alignment of pattern and wildcards.
// ----------------------------------------------------------------------------
module msig_cfg #(
	parameter int LIM = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	msig_cfg_if.sink            cfg,
	output msig_pkg::ctl_t      ctl,
	output logic [LIM-1:0]      care,
	output logic [LIM-1:0][7:0] pat
);

	localparam int LW = msig_pkg::LEN_W;

	logic [4*msig_pkg::CFG_DATA_W-1:0] pattern_q;
	logic [msig_pkg::SLOT_MAX-1:0]     mask_q;
	logic [LW-1:0]                     length_q;
	logic                              find_all_q;
	logic [LW-1:0]                     len;
	logic [LIM-1:0]                    care_q;
	logic [LIM-1:0][7:0]               pat_q;
	logic [LIM-1:0]                    care_d;
	logic [LIM-1:0][7:0]               pat_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			mask_q     <= '0;
			length_q   <= LW'(1);
			find_all_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				msig_pkg::CFG_PATTERN_0: pattern_q[0*64 +: 64] <= cfg.data;
				msig_pkg::CFG_PATTERN_1: pattern_q[1*64 +: 64] <= cfg.data;
				msig_pkg::CFG_PATTERN_2: pattern_q[2*64 +: 64] <= cfg.data;
				msig_pkg::CFG_PATTERN_3: pattern_q[3*64 +: 64] <= cfg.data;
				msig_pkg::CFG_WILDCARD:  mask_q <= cfg.data[msig_pkg::SLOT_MAX-1:0];
				msig_pkg::CFG_LENGTH:    length_q <= cfg.data[LW-1:0];
				msig_pkg::CFG_FIND_ALL:  find_all_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len = length_q;
		if (length_q == '0) begin
			len = LW'(1);
		end else if (length_q > LW'(LIM)) begin
			len = LW'(LIM);
		end
	end

	// cell j holds the byte that arrived j transfers ago: pattern byte len-1-j
	always_comb begin
		logic [LW-1:0] idx;
		for (int j = 0; j < LIM; j++) begin
			idx       = len - LW'(1) - LW'(j);
			care_d[j] = (LW'(j) < len) && !mask_q[idx[4:0]];
			pat_d[j]  = pattern_q[{idx[4:0], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q <= '0;
			pat_q  <= '0;
		end else begin
			care_q <= care_d;
			pat_q  <= pat_d;
		end
	end

	assign ctl.len      = len;
	assign ctl.find_all = find_all_q;
	assign care         = care_q;
	assign pat          = pat_q;

endmodule

// ===== rtl/msig_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msig_outq
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module msig_outq #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  msig_pkg::res_t             push_a,
	input  msig_pkg::res_t             push_b,
	output logic [$clog2(DEPTH+1)-1:0] count,
	msig_out_if.source                 result
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	msig_pkg::res_t       mem_q [DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [CW-1:0]        count_q;
	logic                 pop;
	msig_pkg::res_t       head;

	assign pop  = result.valid && result.ready;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push_cnt);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	assign count                 = count_q;
	assign result.valid          = (count_q != '0);
	assign result.match_offset   = head.match_offset;
	assign result.is_match       = head.is_match;
	assign result.last_of_region = head.last_of_region;

endmodule

// ===== rtl/masked_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// A result is offered after its byte passes the compare stage register and
// the result queue. One byte per cycle while the queue has room; the queue
// drains one result per cycle while ready is high; a byte with a match and
// a region end queues two. Reset clears region state, queue and configuration
// (length 1, first-match mode); window cells are qualified by the byte count.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan #(
	parameter int PATTERN_MAX = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	msig_in_if.sink    byte_stream,
	msig_out_if.source result,
	msig_cfg_if.sink   cfg
);

	localparam int LIM    = (PATTERN_MAX < msig_pkg::SLOT_MAX) ? PATTERN_MAX : msig_pkg::SLOT_MAX;
	localparam int SEEN_W = $clog2(PATTERN_MAX + 1);
	localparam int LW     = msig_pkg::LEN_W;
	localparam int CMP_W  = (SEEN_W > LW) ? SEEN_W : LW;
	localparam int EXT_W  = (OFFSET_BITS > msig_pkg::OFS_OUT_W) ? OFFSET_BITS : msig_pkg::OFS_OUT_W;
	localparam int DEPTH  = msig_pkg::OUTQ_DEPTH;
	localparam int QCW    = $clog2(DEPTH + 1);
	localparam int RW     = QCW + 2;

	msig_pkg::ctl_t      ctl;
	logic [LIM-1:0]      care;
	logic [LIM-1:0][7:0] pat;
	logic [LIM-1:0][7:0] win;
	logic [LIM-1:0]      hits;

	logic                   fire;
	logic [SEEN_W-1:0]      seen_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [SEEN_W-1:0]      seen_base;
	logic [SEEN_W-1:0]      seen_inc;
	logic [OFFSET_BITS-1:0] here0;

	logic                   valid_s1;
	logic                   start_s1;
	logic                   last_s1;
	logic [SEEN_W-1:0]      seen_s1;
	logic [OFFSET_BITS-1:0] here_s1;

	logic [LW-1:0]          hold_q;
	logic                   found_q;
	logic [LW-1:0]          hold_b;
	logic                   found_b;
	logic [LW-1:0]          hold_d;
	logic                   found_d;
	logic                   match;
	logic                   report;
	logic                   match_fire;
	logic                   end_fire;
	logic [OFFSET_BITS-1:0] start_ofs;
	logic [EXT_W-1:0]       start_ext;

	logic [1:0]             push_cnt;
	msig_pkg::res_t         match_res;
	msig_pkg::res_t         end_res;
	msig_pkg::res_t         push_a;
	logic [QCW-1:0]         q_count;
	logic [RW-1:0]          need;

	msig_cfg #(.LIM(LIM)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctl    (ctl),
		.care   (care),
		.pat    (pat)
	);

	assign fire = byte_stream.valid && byte_stream.ready;

	for (genvar j = 0; j < LIM; j++) begin : g_cell
		logic [7:0] chain_in;
		if (j == 0) begin : g_head
			assign chain_in = byte_stream.data_byte;
		end else begin : g_link
			assign chain_in = win[j-1];
		end
		msig_cell u_cell (
			.clk     (clk),
			.shift   (fire),
			.byte_in (chain_in),
			.care    (care[j]),
			.pat     (pat[j]),
			.byte_q  (win[j]),
			.hit     (hits[j])
		);
	end

	// byte stage: count bytes and offsets of the region
	assign seen_base = byte_stream.region_start ? '0 : seen_q;
	assign seen_inc  = (seen_base == SEEN_W'(PATTERN_MAX)) ? seen_base : seen_base + SEEN_W'(1);
	assign here0     = byte_stream.region_start ? '0 : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			offset_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
			if (fire) begin
				seen_q   <= byte_stream.region_last ? '0 : seen_inc;
				offset_q <= byte_stream.region_last ? '0 : here0 + OFFSET_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			start_s1 <= byte_stream.region_start;
			last_s1  <= byte_stream.region_last;
			seen_s1  <= seen_inc;
			here_s1  <= here0;
		end
	end

	// compare stage: match decision, hold-off and first-found tracking
	assign hold_b  = start_s1 ? '0 : hold_q;
	assign found_b = start_s1 ? 1'b0 : found_q;
	assign match   = (&hits) && (CMP_W'(seen_s1) >= CMP_W'(ctl.len));
	assign report  = ctl.find_all ? (hold_b == '0) : !found_b;

	always_comb begin
		hold_d  = hold_b;
		found_d = found_b;
		if (ctl.find_all && (hold_b != '0)) begin
			hold_d = hold_b - LW'(1);
		end
		if (match && report) begin
			hold_d  = ctl.len - LW'(1);
			found_d = 1'b1;
		end
		if (last_s1) begin
			hold_d  = '0;
			found_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			found_q <= 1'b0;
		end else if (valid_s1) begin
			hold_q  <= hold_d;
			found_q <= found_d;
		end
	end

	assign start_ofs  = here_s1 - OFFSET_BITS'(ctl.len - LW'(1));
	assign start_ext  = EXT_W'(start_ofs);
	assign match_fire = valid_s1 && match && report;
	assign end_fire   = valid_s1 && last_s1;

	assign match_res.match_offset   = start_ext[msig_pkg::OFS_OUT_W-1:0];
	assign match_res.is_match       = 1'b1;
	assign match_res.last_of_region = 1'b0;
	assign end_res.match_offset     = '0;
	assign end_res.is_match         = 1'b0;
	assign end_res.last_of_region   = 1'b1;

	assign push_cnt = 2'(match_fire) + 2'(end_fire);
	assign push_a   = match_fire ? match_res : end_res;

	msig_outq #(.DEPTH(DEPTH)) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push_a   (push_a),
		.push_b   (end_res),
		.count    (q_count),
		.result   (result)
	);

	// leave room for the byte in the compare stage and the next one
	assign need              = RW'(q_count) + (valid_s1 ? RW'(2) : RW'(0)) + RW'(2);
	assign byte_stream.ready = (need <= RW'(DEPTH));

endmodule
